/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off by rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/lprf_pkg.sv */
// ---------------------------------------------------------------------------
// lprf_pkg
// Types and codes shared by the record ring FIFO front end, back end and top.
// ---------------------------------------------------------------------------
package lprf_pkg;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_PEEK  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_in;
    logic       first_byte;
    logic [6:0] record_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  data_out;
    logic        last;
    logic [1:0]  status;
    logic [10:0] free_bytes;
    logic        is_empty;
    logic        fits;
  } out_item_t;

  typedef enum logic [2:0] {
    K_PUSH_FIRST,
    K_PUSH_NEXT,
    K_POP,
    K_PEEK,
    K_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic [6:0] rlen;
  } cmd_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_WRITE,
    BS_HEADER,
    BS_STREAM
  } back_state_t;

endpackage

/* rtl/lprf_front.sv */
// ---------------------------------------------------------------------------
// lprf_front
// Accepts requests, classifies them into commands and holds them in a
// two-entry queue for the back end.
// ---------------------------------------------------------------------------
module lprf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  lprf_pkg::in_item_t in_item,
  output logic               busy,
  output logic               q_valid,
  output lprf_pkg::cmd_t     q_cmd,
  input  logic               q_pop
);
  import lprf_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  cmd_t       cmd_new;

  assign busy    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_cmd   = slot_r[rd_ptr_r];
  assign push    = start && !busy;

  always_comb begin
    cmd_new.data = in_item.data_in;
    cmd_new.rlen = in_item.record_length;
    case (in_item.opcode)
      OP_PUSH:  cmd_new.kind = in_item.first_byte ? K_PUSH_FIRST : K_PUSH_NEXT;
      OP_POP:   cmd_new.kind = K_POP;
      OP_PEEK:  cmd_new.kind = K_PEEK;
      OP_CLEAR: cmd_new.kind = K_CLEAR;
      default:  cmd_new.kind = K_CLEAR;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = (q_pop && q_valid) ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !(q_pop && q_valid)) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && q_pop && q_valid) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_new;
    end
  end

endmodule

/* rtl/lprf_back.sv */
// ---------------------------------------------------------------------------
// lprf_back
// Executes queued commands against the byte ring: reserves and writes
// records, reads headers and streams payload bytes as results.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lprf_back #(
  parameter int RING_BYTES   = 1024,
  parameter int HEADER_BYTES = 4,
  parameter int MAX_RECORD   = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  lprf_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  output lprf_pkg::out_item_t out_item
);
  import lprf_pkg::*;

  localparam int PTR_W  = $clog2(RING_BYTES);
  localparam int FREE_W = $clog2(RING_BYTES + 1);
  localparam int HIDX_W = $clog2(HEADER_BYTES + 1);
  localparam int CNT_W  = $clog2(MAX_RECORD + 1);

  logic [7:0] ring_mem [RING_BYTES];
  logic [7:0] rd_data_r;

  back_state_t       state_r, state_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [PTR_W-1:0]  pos_r, pos_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;
  logic [6:0]        prem_r, prem_nxt;
  logic              pdrop_r, pdrop_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [HIDX_W-1:0] idx_r, idx_nxt;
  logic [31:0]       len_r, len_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic              wr_en, rd_en;
  logic [PTR_W-1:0]  wr_addr, rd_addr;
  logic [7:0]        wr_data;
  logic [7:0]        o_data;
  logic              o_last;
  logic [1:0]        o_status;
  logic [6:0]        rlen_cur;
  logic              push_bad;
  logic [31:0]       len_full;
  logic [CNT_W-1:0]  cnt_cap, cnt_calc;
  logic [PTR_W:0]    head_sum;
  logic [PTR_W-1:0]  head_new;
  logic [FREE_W:0]   free_sum;
  logic [FREE_W-1:0] free_sat;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_BYTES - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    rlen_cur = (state_r == BS_IDLE) ? q_cmd.rlen : cmd_r.rlen;
    push_bad = (q_cmd.rlen == 7'd0) || (32'(q_cmd.rlen) > 32'(MAX_RECORD)) ||
               (32'(free_r) < 32'(q_cmd.rlen) + 32'(HEADER_BYTES));

    len_full = len_r | (32'(rd_data_r) << {idx_r, 3'b000});
    cnt_cap  = (len_full > 32'(MAX_RECORD)) ? CNT_W'(MAX_RECORD) : CNT_W'(len_full);
    cnt_calc = cnt_cap;
    if ((cmd_r.kind == K_PEEK) && (32'(cnt_cap) > 32'(cmd_r.rlen))) begin
      cnt_calc = CNT_W'(cmd_r.rlen);
    end
    head_sum = {1'b0, pos_r} + (PTR_W+1)'(cnt_calc);
    head_new = (head_sum >= (PTR_W+1)'(RING_BYTES)) ?
               PTR_W'(head_sum - (PTR_W+1)'(RING_BYTES)) : PTR_W'(head_sum);
    free_sum = (FREE_W+1)'(free_r) + (FREE_W+1)'(cnt_calc) +
               (FREE_W+1)'(HEADER_BYTES);
    free_sat = (free_sum > (FREE_W+1)'(RING_BYTES)) ?
               FREE_W'(RING_BYTES) : FREE_W'(free_sum);
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    pos_nxt       = pos_r;
    free_nxt      = free_r;
    prem_nxt      = prem_r;
    pdrop_nxt     = pdrop_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = tail_r;
    wr_data       = 8'd0;
    rd_en         = 1'b0;
    rd_addr       = pos_r;
    out_valid_nxt = 1'b0;
    o_data        = 8'd0;
    o_last        = 1'b1;
    o_status      = ST_DONE;

    case (state_r)
      BS_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          cmd_nxt       = q_cmd;
          out_valid_nxt = 1'b1;
          case (q_cmd.kind)
            K_PUSH_FIRST: begin
              if (push_bad) begin
                prem_nxt  = (q_cmd.rlen != 7'd0) ? q_cmd.rlen - 7'd1 : 7'd0;
                pdrop_nxt = (prem_nxt != 7'd0);
                o_status  = ST_REJECT;
              end else begin
                free_nxt  = free_r - FREE_W'(32'(q_cmd.rlen) + 32'(HEADER_BYTES));
                prem_nxt  = q_cmd.rlen - 7'd1;
                pdrop_nxt = 1'b0;
                idx_nxt   = '0;
                state_nxt = BS_WRITE;
              end
            end
            K_PUSH_NEXT: begin
              if (prem_r != 7'd0) begin
                prem_nxt = prem_r - 7'd1;
                if (pdrop_r) begin
                  o_status = ST_REJECT;
                end else begin
                  wr_en    = 1'b1;
                  wr_data  = q_cmd.data;
                  tail_nxt = ptr_inc(tail_r);
                end
                if (prem_r == 7'd1) begin
                  pdrop_nxt = 1'b0;
                end
              end
            end
            K_POP, K_PEEK: begin
              if (free_r == FREE_W'(RING_BYTES)) begin
                o_status = ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                rd_en         = 1'b1;
                rd_addr       = head_r;
                pos_nxt       = ptr_inc(head_r);
                idx_nxt       = '0;
                len_nxt       = '0;
                state_nxt     = BS_HEADER;
              end
            end
            K_CLEAR: begin
              head_nxt  = '0;
              tail_nxt  = '0;
              free_nxt  = FREE_W'(RING_BYTES);
              prem_nxt  = 7'd0;
              pdrop_nxt = 1'b0;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      BS_WRITE: begin
        wr_en    = 1'b1;
        tail_nxt = ptr_inc(tail_r);
        idx_nxt  = idx_r + HIDX_W'(1);
        if (idx_r == HIDX_W'(HEADER_BYTES)) begin
          wr_data   = cmd_r.data;
          state_nxt = BS_IDLE;
        end else if (idx_r == '0) begin
          wr_data = {1'b0, cmd_r.rlen};
        end
      end
      BS_HEADER: begin
        rd_en   = 1'b1;
        pos_nxt = ptr_inc(pos_r);
        len_nxt = len_full;
        idx_nxt = idx_r + HIDX_W'(1);
        if (idx_r == HIDX_W'(HEADER_BYTES - 1)) begin
          cnt_nxt = cnt_calc;
          k_nxt   = '0;
          if (cmd_r.kind == K_POP) begin
            head_nxt = head_new;
            free_nxt = free_sat;
          end
          if (cnt_calc == '0) begin
            out_valid_nxt = 1'b1;
            state_nxt     = BS_IDLE;
          end else begin
            state_nxt = BS_STREAM;
          end
        end
      end
      BS_STREAM: begin
        out_valid_nxt = 1'b1;
        o_data        = rd_data_r;
        o_last        = (k_r == cnt_r - CNT_W'(1));
        rd_en         = 1'b1;
        pos_nxt       = ptr_inc(pos_r);
        k_nxt         = k_r + CNT_W'(1);
        if (o_last) begin
          state_nxt = BS_IDLE;
        end
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase

    out_nxt.data_out   = o_data;
    out_nxt.last       = o_last;
    out_nxt.status     = o_status;
    out_nxt.free_bytes = 11'(free_nxt);
    out_nxt.is_empty   = (free_nxt == FREE_W'(RING_BYTES));
    out_nxt.fits       = (32'(rlen_cur) + 32'(HEADER_BYTES)) <= 32'(free_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      free_r      <= FREE_W'(RING_BYTES);
      prem_r      <= 7'd0;
      pdrop_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_r      <= free_nxt;
      prem_r      <= prem_nxt;
      pdrop_r     <= pdrop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    len_r <= len_nxt;
    cnt_r <= cnt_nxt;
    k_r   <= k_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= ring_mem[rd_addr];
    end
  end

  `ASSERT_ALWAYS(a_free_bound, free_r <= FREE_W'(RING_BYTES), "free count above ring size")
  `ASSERT_ALWAYS(a_port_excl, !(wr_en && rd_en), "ring read and write in the same cycle")
  `ASSERT_IMPLIES(a_stream_idx, state_r == BS_STREAM, (cnt_r != '0) && (k_r < cnt_r), "stream index out of range")
  `ASSERT_NEXT(a_clear, (state_r == BS_IDLE) && q_valid && (q_cmd.kind == K_CLEAR), (free_r == FREE_W'(RING_BYTES)) && (head_r == '0) && (tail_r == '0), "clear left the ring non-empty")

endmodule

/* rtl/length_prefixed_record_ring_fifo.sv */
// ---------------------------------------------------------------------------
// length_prefixed_record_ring_fifo
// Byte ring holding variable-length records behind a length header.
// ---------------------------------------------------------------------------
// A request is taken on a clock edge where start is high and busy is low.
// Requests push one byte, pop the oldest record, peek at it or clear the ring.
// Each result appears on out_item for one cycle with out_valid high; the
// receiver cannot hold results off, and last marks the final result of a
// request. Requests wait in a two-entry queue, and busy is high while it is
// full.
// When the back end is free, a request passes through a queue slot and the
// back end's result register before its first result reaches the ports. A
// first push byte keeps the back end busy while the header and then the byte
// are written through the single ring write port. A pop or peek reads the
// header bytes and then streams the payload, one result per cycle from the
// registered ring read port. Later push bytes, clear and empty results come
// straight from the idle state.
// Reset empties the ring at once with no clearing pass.
// ---------------------------------------------------------------------------
module length_prefixed_record_ring_fifo #(
  parameter int RING_BYTES   = 1024,
  parameter int HEADER_BYTES = 4,
  parameter int MAX_RECORD   = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lprf_pkg::in_item_t  in_item,
  output logic                out_valid,
  output lprf_pkg::out_item_t out_item
);
  import lprf_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  lprf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .busy    (busy),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  lprf_back #(
    .RING_BYTES   (RING_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_RECORD   (MAX_RECORD)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

/* dv/tb_length_prefixed_record_ring_fifo.sv */
// ---------------------------------------------------------------------------
// Record ring FIFO testbench
// Drives push, pop, peek and clear requests into the ring and checks every
// result strobe, field by field and in order, against a predicted copy of the
// ring. A short table covers the edge cases. Random traffic follows, under
// several idle patterns, and only reads ring bytes that have been written.
// ---------------------------------------------------------------------------
module tb_length_prefixed_record_ring_fifo;
  timeunit 1ns;
  timeprecision 1ps;

  import lprf_pkg::*;

  localparam int RING_BYTES   = 1024;
  localparam int HEADER_BYTES = 4;
  localparam int MAX_RECORD   = 64;
  localparam int CLK_HALF     = 5;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct packed {
    in_item_t  req;
    logic      typed;
    out_item_t want;
  } directed_row_t;

  localparam out_item_t NO_WANT      = '0;
  localparam out_item_t WANT_EMPTY   = '{8'h00, 1'b1, ST_EMPTY, 11'd1024, 1'b1, 1'b1};
  localparam out_item_t WANT_IDLE_OK = '{8'h00, 1'b1, ST_DONE, 11'd1024, 1'b1, 1'b1};
  localparam out_item_t WANT_REJECT  = '{8'h00, 1'b1, ST_REJECT, 11'd1024, 1'b1, 1'b1};
  localparam out_item_t WANT_FIRST64 = '{8'h00, 1'b1, ST_DONE, 11'd956, 1'b0, 1'b1};

  localparam directed_row_t DIRECTED_ROWS [23] = '{
    '{'{OP_POP,   8'h00, 1'b0, 7'd5},   1'b1, WANT_EMPTY},
    '{'{OP_PEEK,  8'h00, 1'b0, 7'd127}, 1'b1, WANT_EMPTY},
    '{'{OP_PUSH,  8'hFF, 1'b0, 7'd0},   1'b1, WANT_IDLE_OK},
    '{'{OP_PUSH,  8'h55, 1'b1, 7'd0},   1'b1, WANT_REJECT},
    '{'{OP_PUSH,  8'hA5, 1'b1, 7'd127}, 1'b1, WANT_REJECT},
    '{'{OP_PUSH,  8'h3C, 1'b0, 7'd127}, 1'b1, WANT_REJECT},
    '{'{OP_CLEAR, 8'h00, 1'b0, 7'd64},  1'b1, WANT_IDLE_OK},
    '{'{OP_PUSH,  8'h00, 1'b1, 7'd64},  1'b1, WANT_FIRST64},
    '{'{OP_PUSH,  8'hFF, 1'b0, 7'd64},  1'b0, NO_WANT},
    '{'{OP_PUSH,  8'h80, 1'b0, 7'd1},   1'b0, NO_WANT},
    '{'{OP_PUSH,  8'h7F, 1'b0, 7'd100}, 1'b0, NO_WANT},
    '{'{OP_PEEK,  8'h00, 1'b0, 7'd3},   1'b0, NO_WANT},
    '{'{OP_PEEK,  8'h00, 1'b0, 7'd0},   1'b0, NO_WANT},
    '{'{OP_PUSH,  8'h5A, 1'b1, 7'd1},   1'b0, NO_WANT},
    '{'{OP_CLEAR, 8'h00, 1'b0, 7'd0},   1'b1, WANT_IDLE_OK},
    '{'{OP_PUSH,  8'h3C, 1'b1, 7'd1},   1'b0, NO_WANT},
    '{'{OP_PUSH,  8'h01, 1'b1, 7'd2},   1'b0, NO_WANT},
    '{'{OP_PUSH,  8'hFE, 1'b0, 7'd2},   1'b0, NO_WANT},
    '{'{OP_PEEK,  8'h00, 1'b0, 7'd127}, 1'b0, NO_WANT},
    '{'{OP_POP,   8'h00, 1'b0, 7'd0},   1'b0, NO_WANT},
    '{'{OP_POP,   8'h00, 1'b0, 7'd64},  1'b0, NO_WANT},
    '{'{OP_POP,   8'h00, 1'b0, 7'd9},   1'b1, WANT_EMPTY},
    '{'{OP_PUSH,  8'h99, 1'b0, 7'd64},  1'b0, NO_WANT}
  };

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  logic [7:0]  ring_image [RING_BYTES];
  bit          ring_written [RING_BYTES];
  logic [9:0]  ring_head = '0;
  logic [9:0]  ring_tail = '0;
  logic [10:0] ring_free = 11'(RING_BYTES);
  logic [6:0]  bytes_owed = '0;
  logic        dropping_record = 1'b0;

  out_item_t pending_results [$];
  int        mismatch_count = 0;
  int        cycle_count = 0;

  length_prefixed_record_ring_fifo #(
    .RING_BYTES  (RING_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_RECORD  (MAX_RECORD)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic in_item_t make_req(logic [1:0] op, logic [7:0] data, logic first,
                                        logic [6:0] rlen);
    in_item_t req;
    req.opcode        = op;
    req.data_in       = data;
    req.first_byte    = first;
    req.record_length = rlen;
    return req;
  endfunction

  function automatic void store_byte(logic [7:0] value);
    ring_image[ring_tail]   = value;
    ring_written[ring_tail] = 1'b1;
    ring_tail = ring_tail + 10'd1;
  endfunction

  // A pop or peek issued now would only touch ring bytes that hold known data.
  function automatic logic read_is_safe();
    logic [9:0]  pos;
    logic [31:0] len;
    int          cnt;
    if (ring_free == RING_BYTES) begin
      return 1'b1;
    end
    pos = ring_head;
    len = '0;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      if (!ring_written[pos]) begin
        return 1'b0;
      end
      len = len | (32'(ring_image[pos]) << (8 * i));
      pos = pos + 10'd1;
    end
    cnt = (len > MAX_RECORD) ? MAX_RECORD : int'(len);
    for (int k = 0; k < cnt; k++) begin
      if (!ring_written[pos]) begin
        return 1'b0;
      end
      pos = pos + 10'd1;
    end
    return 1'b1;
  endfunction

  function automatic void predict_ring_results(in_item_t req);
    out_item_t  batch [$];
    out_item_t  r;
    logic [9:0] pos;
    logic [31:0] len;
    int         cnt;
    r = '0;
    case (req.opcode)
      OP_PUSH: begin
        if (req.first_byte) begin
          if (req.record_length == 0 || req.record_length > MAX_RECORD ||
              ring_free < req.record_length + HEADER_BYTES) begin
            bytes_owed = (req.record_length != 0) ? req.record_length - 7'd1 : 7'd0;
            dropping_record = (bytes_owed != 0);
            r.status = ST_REJECT;
          end else begin
            ring_free = ring_free - 11'(req.record_length + HEADER_BYTES);
            for (int i = 0; i < HEADER_BYTES; i++) begin
              store_byte(8'(32'(req.record_length) >> (8 * i)));
            end
            store_byte(req.data_in);
            bytes_owed = req.record_length - 7'd1;
            dropping_record = 1'b0;
            r.status = ST_DONE;
          end
        end else if (bytes_owed != 0) begin
          bytes_owed = bytes_owed - 7'd1;
          if (dropping_record) begin
            r.status = ST_REJECT;
          end else begin
            store_byte(req.data_in);
            r.status = ST_DONE;
          end
          if (bytes_owed == 0) begin
            dropping_record = 1'b0;
          end
        end else begin
          r.status = ST_DONE;
        end
        batch.push_back(r);
      end
      OP_POP, OP_PEEK: begin
        if (ring_free == RING_BYTES) begin
          r.status = ST_EMPTY;
          batch.push_back(r);
        end else begin
          pos = ring_head;
          len = '0;
          for (int i = 0; i < HEADER_BYTES; i++) begin
            len = len | (32'(ring_image[pos]) << (8 * i));
            pos = pos + 10'd1;
          end
          cnt = (len > MAX_RECORD) ? MAX_RECORD : int'(len);
          if (req.opcode == OP_PEEK && cnt > req.record_length) begin
            cnt = req.record_length;
          end
          for (int k = 0; k < cnt; k++) begin
            r.data_out = ring_image[pos];
            r.status   = ST_DONE;
            batch.push_back(r);
            pos = pos + 10'd1;
          end
          if (cnt == 0) begin
            r.status = ST_DONE;
            batch.push_back(r);
          end
          if (req.opcode == OP_POP) begin
            ring_head = pos;
            if (ring_free + cnt + HEADER_BYTES > RING_BYTES) begin
              ring_free = 11'(RING_BYTES);
            end else begin
              ring_free = 11'(ring_free + cnt + HEADER_BYTES);
            end
          end
        end
      end
      OP_CLEAR: begin
        ring_head = '0;
        ring_tail = '0;
        ring_free = 11'(RING_BYTES);
        bytes_owed = '0;
        dropping_record = 1'b0;
        r.status = ST_DONE;
        batch.push_back(r);
      end
      default: begin
      end
    endcase
    foreach (batch[k]) begin
      batch[k].free_bytes = ring_free;
      batch[k].is_empty   = (ring_free == RING_BYTES);
      batch[k].fits       = (req.record_length + HEADER_BYTES <= ring_free);
      batch[k].last       = (k == batch.size() - 1);
      pending_results.push_back(batch[k]);
    end
  endfunction

  function automatic logic [6:0] record_size();
    int pick;
    pick = $urandom_range(99);
    if (pick < 3) return 7'd0;
    if (pick < 10) return 7'($urandom_range(127, MAX_RECORD + 1));
    if (pick < 25) return 7'(MAX_RECORD);
    return 7'($urandom_range(MAX_RECORD, 1));
  endfunction

  task automatic issue_request(in_item_t req, int idle_pct);
    in_item <= req;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_ring_results(req);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Mostly whole records with random content, interleaved with reads, plus
  // abandoned records, stray bytes and the odd clear.
  task automatic run_random(int quota, int idle_pct);
    int       counted;
    int       pick;
    logic     ignored;
    in_item_t req;
    counted = 0;
    while (counted < quota) begin
      pick = $urandom_range(99);
      req  = make_req(OP_PUSH, 8'($urandom_range(255)), 1'b0, 7'($urandom_range(127)));
      if (bytes_owed != 0) begin
        if (pick >= 99) begin
          req.opcode = OP_CLEAR;
        end else if (pick >= 94) begin
          req.first_byte    = 1'b1;
          req.record_length = record_size();
        end else if (pick >= 86) begin
          req.opcode = OP_PEEK;
        end else if (pick >= 78) begin
          req.opcode = OP_POP;
        end
      end else begin
        if (pick < 50) begin
          req.first_byte    = 1'b1;
          req.record_length = record_size();
        end else if (pick < 72) begin
          req.opcode = OP_POP;
        end else if (pick < 92) begin
          req.opcode = OP_PEEK;
        end else if (pick < 95) begin
          req.opcode = OP_CLEAR;
        end
      end
      if ((req.opcode == OP_POP || req.opcode == OP_PEEK) && !read_is_safe()) begin
        req.opcode = (bytes_owed != 0) ? OP_PUSH : OP_CLEAR;
      end
      ignored = (req.opcode == OP_PUSH && !req.first_byte && bytes_owed == 0);
      issue_request(req, idle_pct);
      if (!ignored) begin
        counted++;
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: data %02h last %0d status %0d free %0d",
                   out_item.data_out, out_item.last, out_item.status, out_item.free_bytes);
        end
      end else begin
        want = pending_results.pop_front();
        if (want.data_out !== out_item.data_out || want.last !== out_item.last ||
            want.status !== out_item.status || want.free_bytes !== out_item.free_bytes ||
            want.is_empty !== out_item.is_empty || want.fits !== out_item.fits) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display({"result mismatch: expected data %02h last %0d status %0d free %0d ",
                      "empty %0d fits %0d, got data %02h last %0d status %0d free %0d ",
                      "empty %0d fits %0d"},
                     want.data_out, want.last, want.status, want.free_bytes,
                     want.is_empty, want.fits, out_item.data_out, out_item.last,
                     out_item.status, out_item.free_bytes, out_item.is_empty, out_item.fits);
          end
        end
      end
    end
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("length_prefixed_record_ring_fifo test failed");
    $finish;
  end

  initial begin
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED_ROWS[i]) begin
      issue_request(DIRECTED_ROWS[i].req, 0);
      if (DIRECTED_ROWS[i].typed) begin
        pending_results[pending_results.size() - 1] = DIRECTED_ROWS[i].want;
      end
    end
    run_random(25, 0);
    run_random(25, 66);
    wait_for_results();
    run_random(25, 0);
    run_random(25, 27);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatch_count++;
      $display("%0d expected results never arrived", pending_results.size());
    end
    if (mismatch_count == 0) begin
      $display("length_prefixed_record_ring_fifo test passed");
    end else begin
      $display("length_prefixed_record_ring_fifo test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/lprf_pkg.sv
rtl/lprf_front.sv
rtl/lprf_back.sv
rtl/length_prefixed_record_ring_fifo.sv
dv/tb_length_prefixed_record_ring_fifo.sv
